>>> rtl/rational_arithmetic_unit_defines.svh
// assertion macros for the rational arithmetic unit checker
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define RAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rau check failed");

// next-cycle implication
`define RAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rau check failed");

`endif

>>> rtl/rau_pkg.sv
// shared types and constants of the rational arithmetic unit
package rau_pkg;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_SUB = 2'd1;
	localparam logic [1:0] CMD_MUL = 2'd2;
	localparam logic [1:0] CMD_DIV = 2'd3;

	typedef enum logic [3:0] {
		DP_NOP, DP_LOAD, DP_GCD, DP_DIV_MAG, DP_DIV_DEN, DP_FIX, DP_MUL,
		DP_FLAGS, DP_COPY, DP_COMB, DP_SIGN, DP_DZERO, DP_OUT
	} dp_op_t;

	typedef enum logic [1:0] {PAIR_A, PAIR_B, PAIR_X, PAIR_R} pair_t;

	typedef enum logic [3:0] {
		M_CMP_A, M_CMP_B, M_LCM, M_TA, M_TB, M_MN, M_MD, M_DN, M_DD
	} mul_sel_t;

	typedef struct packed {
		dp_op_t   op;
		pair_t    pair;
		mul_sel_t msel;
	} dp_cmd_t;

	typedef struct packed {
		logic       gcd_done;
		logic       div_done;
		logic       b_zero;
		logic [1:0] cmd;
	} dp_status_t;

endpackage

>>> rtl/rational_arithmetic_unit.sv
// top level of the rational arithmetic unit
// multiply and divide run three gcd-and-reduce passes, add and subtract four, each a binary
// gcd and two divisions; throughput: one item at a time, start taken again with done
// done is a one-cycle strobe; res_num, res_den and overflow stay on the ports until the next item finishes
// reset clears the controller and the gcd and divider control; payload is not reset
module rational_arithmetic_unit #(
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] a_num,
	input  logic [30:0]        a_den,
	input  logic signed [31:0] b_num,
	input  logic [30:0]        b_den,
	output logic               done,
	output logic signed [31:0] res_num,
	output logic [30:0]        res_den,
	output logic               is_equal,
	output logic               is_less,
	output logic               is_greater,
	output logic               overflow
);
	import rau_pkg::*;

	dp_cmd_t    ctl;
	dp_status_t status;

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.ctl(ctl), .status(status)
	);

	rau_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .status(status),
		.cmd(cmd), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.res_num(res_num), .res_den(res_den), .is_equal(is_equal),
		.is_less(is_less), .is_greater(is_greater), .overflow(overflow)
	);
endmodule

>>> rtl/rau_gcd.sv
// binary gcd unit, one step per cycle
module rau_gcd (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] x,
	input  logic [63:0] y,
	output logic        done,
	output logic [63:0] g
);
	logic [63:0] u_q, v_q, g_q;
	logic [6:0]  k_q;
	logic        run_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				u_q   <= x;
				v_q   <= y;
				k_q   <= 7'd0;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (u_q == 64'd0) begin
					g_q    <= v_q << k_q;
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else if (v_q == 64'd0) begin
					g_q    <= u_q << k_q;
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + 7'd1;
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_q >= v_q) begin
					u_q <= (u_q - v_q) >> 1;
				end else begin
					v_q <= (v_q - u_q) >> 1;
				end
			end
		end
	end

	assign done = done_q;
	assign g    = g_q;
endmodule

>>> rtl/rau_div.sv
// restoring divider, one quotient bit per cycle
module rau_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] n,
	input  logic [63:0] d,
	output logic        done,
	output logic [63:0] q
);
	logic [63:0] rem_q, quo_q, d_q;
	logic [5:0]  cnt_q;
	logic        run_q, done_q;
	logic [64:0] trial;
	logic        fits;

	always_comb begin
		trial = {rem_q, quo_q[63]};
		fits  = trial >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q <= 64'd0;
				quo_q <= n;
				d_q   <= d;
				cnt_q <= 6'd0;
				run_q <= 1'b1;
			end else if (run_q) begin
				rem_q <= fits ? 64'(trial - {1'b0, d_q}) : trial[63:0];
				quo_q <= {quo_q[62:0], fits};
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign q    = quo_q;
endmodule

>>> rtl/rau_datapath.sv
// operand registers, multiplier, gcd and divider of the rational unit
module rau_datapath #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rau_pkg::dp_cmd_t    ctl,
	output rau_pkg::dp_status_t status,
	input  logic [1:0]          cmd,
	input  logic signed [31:0]  a_num,
	input  logic [30:0]         a_den,
	input  logic signed [31:0]  b_num,
	input  logic [30:0]         b_den,
	output logic signed [31:0]  res_num,
	output logic [30:0]         res_den,
	output logic                is_equal,
	output logic                is_less,
	output logic                is_greater,
	output logic                overflow
);
	import rau_pkg::*;

	localparam logic [63:0] LIM = 64'd1 << (DATA_WIDTH - 1);

	logic [31:0] am_q, ad_q, bm_q, bd_q, x_q, y_q;
	logic        an_q, bn_q, rneg_q;
	logic [63:0] rn_q, rd_q, pa_q, pb_q;
	logic [1:0]  cmd_q;
	pair_t       div_pair_q;
	logic        div_den_q;
	logic        eq_q, lt_q, gt_q, ovf_q;
	logic [31:0] rnum_q;
	logic [30:0] rden_q;

	logic [63:0] sel_mag, sel_den, g, q;
	logic        gcd_done, div_done;
	logic [31:0] ma, mb;
	logic [63:0] prod;
	logic signed [63:0] ca, cb;
	logic        ovf;

	always_comb begin
		case (ctl.pair)
			PAIR_A:  begin sel_mag = {32'd0, am_q}; sel_den = {32'd0, ad_q}; end
			PAIR_B:  begin sel_mag = {32'd0, bm_q}; sel_den = {32'd0, bd_q}; end
			PAIR_X:  begin sel_mag = {32'd0, x_q};  sel_den = {32'd0, y_q};  end
			default: begin sel_mag = rn_q;          sel_den = rd_q;          end
		endcase
	end

	rau_gcd u_gcd (
		.clk(clk), .arst_n(arst_n), .start(ctl.op == DP_GCD),
		.x(sel_mag), .y(sel_den), .done(gcd_done), .g(g)
	);

	rau_div u_div (
		.clk(clk), .arst_n(arst_n),
		.start(ctl.op == DP_DIV_MAG || ctl.op == DP_DIV_DEN),
		.n(ctl.op == DP_DIV_DEN ? sel_den : sel_mag), .d(g),
		.done(div_done), .q(q)
	);

	always_comb begin
		case (ctl.msel)
			M_CMP_A: begin ma = am_q; mb = bd_q; end
			M_CMP_B: begin ma = bm_q; mb = ad_q; end
			M_LCM:   begin ma = x_q;  mb = bd_q; end
			M_TA:    begin ma = am_q; mb = y_q;  end
			M_TB:    begin ma = bm_q; mb = x_q;  end
			M_MN:    begin ma = am_q; mb = bm_q; end
			M_MD:    begin ma = ad_q; mb = bd_q; end
			M_DN:    begin ma = am_q; mb = bd_q; end
			M_DD:    begin ma = ad_q; mb = bm_q; end
			default: begin ma = am_q; mb = bd_q; end
		endcase
		prod = {32'd0, ma} * {32'd0, mb};
		ca   = an_q ? $signed(64'd0 - pa_q) : $signed(pa_q);
		cb   = bn_q ? $signed(64'd0 - pb_q) : $signed(pb_q);
		ovf  = (rd_q > LIM - 64'd1) || (rneg_q ? (rn_q > LIM) : (rn_q > LIM - 64'd1));
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			case (div_pair_q)
				PAIR_A:  if (div_den_q) ad_q <= q[31:0]; else am_q <= q[31:0];
				PAIR_B:  if (div_den_q) bd_q <= q[31:0]; else bm_q <= q[31:0];
				PAIR_X:  if (div_den_q) y_q <= q[31:0]; else x_q <= q[31:0];
				default: if (div_den_q) rd_q <= q; else rn_q <= q;
			endcase
		end
		case (ctl.op)
			DP_LOAD: begin
				cmd_q <= cmd;
				an_q  <= a_num[31];
				am_q  <= a_num[31] ? (~a_num + 32'd1) : a_num;
				ad_q  <= (a_den == 31'd0) ? 32'd1 : {1'b0, a_den};
				bn_q  <= b_num[31];
				bm_q  <= b_num[31] ? (~b_num + 32'd1) : b_num;
				bd_q  <= (b_den == 31'd0) ? 32'd1 : {1'b0, b_den};
			end
			DP_DIV_MAG, DP_DIV_DEN: begin
				div_pair_q <= ctl.pair;
				div_den_q  <= ctl.op == DP_DIV_DEN;
			end
			DP_FIX: begin
				case (ctl.pair)
					PAIR_A:  an_q   <= an_q && (am_q != 32'd0);
					PAIR_B:  bn_q   <= bn_q && (bm_q != 32'd0);
					PAIR_R:  rneg_q <= rneg_q && (rn_q != 64'd0);
					default: ;
				endcase
			end
			DP_MUL: begin
				case (ctl.msel)
					M_CMP_A, M_TA:      pa_q <= prod;
					M_CMP_B, M_TB:      pb_q <= prod;
					M_LCM, M_MD, M_DD:  rd_q <= prod;
					default:            rn_q <= prod;
				endcase
			end
			DP_FLAGS: begin
				eq_q <= ca == cb;
				lt_q <= ca < cb;
				gt_q <= ca > cb;
			end
			DP_COPY: begin
				x_q <= ad_q;
				y_q <= bd_q;
				if (cmd_q == CMD_SUB)
					bn_q <= !bn_q && (bm_q != 32'd0);
			end
			DP_COMB: begin
				if (an_q == bn_q) begin
					rn_q   <= pa_q + pb_q;
					rneg_q <= an_q;
				end else if (pa_q >= pb_q) begin
					rn_q   <= pa_q - pb_q;
					rneg_q <= an_q;
				end else begin
					rn_q   <= pb_q - pa_q;
					rneg_q <= bn_q;
				end
			end
			DP_SIGN: rneg_q <= an_q ^ bn_q;
			DP_DZERO: begin
				rn_q   <= {32'd0, am_q};
				rd_q   <= {32'd0, ad_q};
				rneg_q <= an_q;
			end
			DP_OUT: begin
				ovf_q  <= ovf;
				rnum_q <= ovf ? 32'd0 : (rneg_q ? (~rn_q[31:0] + 32'd1) : rn_q[31:0]);
				rden_q <= ovf ? 31'd0 : rd_q[30:0];
			end
			default: ;
		endcase
	end

	assign status.gcd_done = gcd_done;
	assign status.div_done = div_done;
	assign status.b_zero   = bm_q == 32'd0;
	assign status.cmd      = cmd_q;

	assign res_num    = rnum_q;
	assign res_den    = rden_q;
	assign is_equal   = eq_q;
	assign is_less    = lt_q;
	assign is_greater = gt_q;
	assign overflow   = ovf_q;
endmodule

>>> rtl/rau_ctrl.sv
// sequencing state machine of the rational unit
module rau_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output rau_pkg::dp_cmd_t    ctl,
	input  rau_pkg::dp_status_t status
);
	import rau_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_RG, S_RGW, S_RDM, S_RDMW, S_RDD, S_RDDW, S_RFIX,
		S_CMP1, S_CMP2, S_FLAG, S_COPY, S_LCM, S_TA, S_TB, S_COMB,
		S_MN, S_MD, S_DN, S_DD, S_SIGN, S_DZ, S_OUT
	} state_t;

	state_t state_q;
	pair_t  pair_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pair_q  <= PAIR_A;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: if (start) begin
					state_q <= S_RG;
					pair_q  <= PAIR_A;
				end
				S_RG:   state_q <= S_RGW;
				S_RGW:  if (status.gcd_done) state_q <= S_RDM;
				S_RDM:  state_q <= S_RDMW;
				S_RDMW: if (status.div_done) state_q <= S_RDD;
				S_RDD:  state_q <= S_RDDW;
				S_RDDW: if (status.div_done) state_q <= S_RFIX;
				S_RFIX: begin
					case (pair_q)
						PAIR_A: begin
							pair_q  <= PAIR_B;
							state_q <= S_RG;
						end
						PAIR_B:  state_q <= S_CMP1;
						PAIR_X:  state_q <= S_LCM;
						default: state_q <= S_OUT;
					endcase
				end
				S_CMP1: state_q <= S_CMP2;
				S_CMP2: state_q <= S_FLAG;
				S_FLAG: begin
					case (status.cmd)
						CMD_ADD, CMD_SUB: state_q <= S_COPY;
						CMD_MUL:          state_q <= S_MN;
						default:          state_q <= status.b_zero ? S_DZ : S_DN;
					endcase
				end
				S_COPY: begin
					pair_q  <= PAIR_X;
					state_q <= S_RG;
				end
				S_LCM:  state_q <= S_TA;
				S_TA:   state_q <= S_TB;
				S_TB:   state_q <= S_COMB;
				S_MN:   state_q <= S_MD;
				S_MD:   state_q <= S_SIGN;
				S_DN:   state_q <= S_DD;
				S_DD:   state_q <= S_SIGN;
				S_COMB, S_SIGN, S_DZ: begin
					pair_q  <= PAIR_R;
					state_q <= S_RG;
				end
				S_OUT: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl.op   = DP_NOP;
		ctl.pair = pair_q;
		ctl.msel = M_CMP_A;
		case (state_q)
			S_IDLE: if (start) ctl.op = DP_LOAD;
			S_RG:   ctl.op = DP_GCD;
			S_RDM:  ctl.op = DP_DIV_MAG;
			S_RDD:  ctl.op = DP_DIV_DEN;
			S_RFIX: ctl.op = DP_FIX;
			S_CMP1: begin ctl.op = DP_MUL; ctl.msel = M_CMP_A; end
			S_CMP2: begin ctl.op = DP_MUL; ctl.msel = M_CMP_B; end
			S_FLAG: ctl.op = DP_FLAGS;
			S_COPY: ctl.op = DP_COPY;
			S_LCM:  begin ctl.op = DP_MUL; ctl.msel = M_LCM; end
			S_TA:   begin ctl.op = DP_MUL; ctl.msel = M_TA; end
			S_TB:   begin ctl.op = DP_MUL; ctl.msel = M_TB; end
			S_COMB: ctl.op = DP_COMB;
			S_MN:   begin ctl.op = DP_MUL; ctl.msel = M_MN; end
			S_MD:   begin ctl.op = DP_MUL; ctl.msel = M_MD; end
			S_DN:   begin ctl.op = DP_MUL; ctl.msel = M_DN; end
			S_DD:   begin ctl.op = DP_MUL; ctl.msel = M_DD; end
			S_SIGN: ctl.op = DP_SIGN;
			S_DZ:   ctl.op = DP_DZERO;
			S_OUT:  ctl.op = DP_OUT;
			default: ctl.op = DP_NOP;
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
endmodule

>>> rtl/rau_checker.sv
// port-level checker of the rational arithmetic unit and its bind
`include "rational_arithmetic_unit_defines.svh"

module rau_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [31:0] res_num,
	input logic [30:0]        res_den,
	input logic               is_equal,
	input logic               is_less,
	input logic               is_greater,
	input logic               overflow
);
	`RAU_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`RAU_ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done)
	`RAU_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`RAU_ASSERT_IMP(a_ovf_zero, clk, arst_n, done && overflow, res_num == 0 && res_den == 0)
	`RAU_ASSERT_IMP(a_flags, clk, arst_n, done, $onehot({is_equal, is_less, is_greater}))
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
